@@ src/stoe_pkg.sv @@
// Shared types and constants of the sprite tile object expander.
`default_nettype none

package stoe_pkg;

	// Item actions
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_RENDER = 1'b1;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_RIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FLIP_X_OFS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FLIP_Y_OFS  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HIDE_WORD   = 3'd6;

	// Register reset values
	localparam logic [15:0] RST_VIEW_LEFT   = 16'd0;
	localparam logic [15:0] RST_VIEW_RIGHT  = 16'd383;
	localparam logic [15:0] RST_VIEW_TOP    = 16'd0;
	localparam logic [15:0] RST_VIEW_BOTTOM = 16'd223;

	// Attribute word flip bits
	localparam logic [15:0] FLIP_MASK   = 16'h3000;
	localparam logic [15:0] FLIP_X_MASK = 16'h2000;
	localparam logic [15:0] FLIP_Y_MASK = 16'h1000;
	localparam int unsigned PALETTE_SHIFT = 14;

	// Geometry
	localparam logic [15:0] TILE_STEP = 16'd8;
	localparam logic [17:0] ROW_MARGIN = 18'd8;
	localparam logic [17:0] COL_MARGIN = 18'd4;

	// Word types
	typedef logic [15:0] word_t;
	typedef logic [17:0] wide_t;

endpackage

`default_nettype wire

@@ src/stoe_if.sv @@
// Channel interfaces: render/load requests, tile results and configuration writes.
`default_nettype none

interface stoe_req_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic        [9:0]  map_address;
	logic        [15:0] map_data;
	logic        [9:0]  map_start;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic        [15:0] attribute_word;
	logic        [1:0]  palette;
	logic        [10:0] char_offset;
	logic        [3:0]  cols;
	logic        [3:0]  rows;
	logic        [9:0]  base_index;

	modport source (
		output valid, action, map_address, map_data, map_start, pos_x, pos_y,
			attribute_word, palette, char_offset, cols, rows, base_index,
		input  ready
	);
	modport sink (
		input  valid, action, map_address, map_data, map_start, pos_x, pos_y,
			attribute_word, palette, char_offset, cols, rows, base_index,
		output ready
	);
endinterface

interface stoe_res_if;
	logic               valid;
	logic               ready;
	logic        [9:0]  obj_index;
	logic               visible;
	logic        [15:0] head_word;
	logic signed [15:0] x_pos;
	logic signed [15:0] y_pos;
	logic        [15:0] tile_word;
	logic               last;

	modport source (
		output valid, obj_index, visible, head_word, x_pos, y_pos, tile_word, last,
		input  ready
	);
	modport sink (
		input  valid, obj_index, visible, head_word, x_pos, y_pos, tile_word, last,
		output ready
	);
endinterface

interface stoe_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  reg_index;
	logic [15:0] data;

	modport source (output valid, reg_index, data, input ready);
	modport sink (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

@@ src/stoe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module stoe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/sprite_tile_object_expander_top.sv @@
// Sprite tile object expander: map store, configuration and tile sequencer.
//
// Channels: "request" carries load and render transactions, "result" carries one
// object entry per tile, "cfg" writes the seven window/flip/hide registers and is
// always ready. All use valid/ready; a transaction moves when both are high.
// A load transaction writes one word into the map store (a synchronous RAM).
// A render transaction walks rows by cols tiles in slot order, reading one map
// word per tile from the RAM; the RAM read port is the per-tile step.
// After acceptance the start address and slot base are folded into range by
// repeated subtraction in the prep state (none is needed at the default sizes).
// Then one tile leaves the sequencer per cycle while the receiver takes results;
// each result passes through the read stage and then the output register.
// "request" is ready again as soon as the last tile read is issued, while the
// last results may still wait in the read stage or the output register.
// When the receiver stalls, tile reads pause and nothing is lost.
// Reset clears the registers to their reset values and empties the pipeline;
// map words stay undefined until loaded.
`default_nettype none

module sprite_tile_object_expander_top #(
	parameter int MAP_DEPTH    = 1024,
	parameter int MAX_COLS     = 8,
	parameter int MAX_ROWS     = 8,
	parameter int OBJECT_SLOTS = 1024
) (
	input wire logic   clk,
	input wire logic   arst_n,
	stoe_req_if.sink   request,
	stoe_res_if.source result,
	stoe_cfg_if.sink   cfg
);

	localparam int AW = $clog2(MAP_DEPTH);
	localparam int OW = $clog2(OBJECT_SLOTS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	// Configuration registers
	stoe_pkg::word_t view_left_q, view_right_q, view_top_q, view_bottom_q, hide_word_q;
	logic [7:0]      flip_x_ofs_q, flip_y_ofs_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_left_q   <= stoe_pkg::RST_VIEW_LEFT;
			view_right_q  <= stoe_pkg::RST_VIEW_RIGHT;
			view_top_q    <= stoe_pkg::RST_VIEW_TOP;
			view_bottom_q <= stoe_pkg::RST_VIEW_BOTTOM;
			flip_x_ofs_q  <= '0;
			flip_y_ofs_q  <= '0;
			hide_word_q   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				stoe_pkg::CFG_VIEW_LEFT:   view_left_q   <= cfg.data;
				stoe_pkg::CFG_VIEW_RIGHT:  view_right_q  <= cfg.data;
				stoe_pkg::CFG_VIEW_TOP:    view_top_q    <= cfg.data;
				stoe_pkg::CFG_VIEW_BOTTOM: view_bottom_q <= cfg.data;
				stoe_pkg::CFG_FLIP_X_OFS:  flip_x_ofs_q  <= cfg.data[7:0];
				stoe_pkg::CFG_FLIP_Y_OFS:  flip_y_ofs_q  <= cfg.data[7:0];
				stoe_pkg::CFG_HIDE_WORD:   hide_word_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Sequencer state and latched transaction
	logic [1:0]      state_q;
	logic            action_q;
	logic [9:0]      start_q;
	logic [9:0]      base_q;
	stoe_pkg::word_t map_data_q, pos_x_q, pos_y_q, attr_q, tbase_q;
	logic [3:0]      cols_q, rows_q, col_q, row_q;
	stoe_pkg::word_t x0_q, x_q, y_q;
	logic [AW-1:0]   addr_q;
	logic [OW-1:0]   obj_q;
	stoe_pkg::wide_t xlim_q, ylim_q;

	// Pipeline: tile read in flight, then output register
	logic            valid_s1;
	logic [OW-1:0]   obj_s1;
	logic            vis_s1, last_s1;
	stoe_pkg::word_t head_s1, x_s1, y_s1, tbase_s1;
	logic            out_valid_q;
	logic [9:0]      out_obj_q;
	logic            out_vis_q, out_last_q;
	stoe_pkg::word_t out_head_q, out_x_q, out_y_q, out_tile_q;

	logic            req_accept, advance, issue;
	logic            start_big, base_big, prep_done;
	logic            flip_x, flip_y, row_end, tile_end;
	stoe_pkg::wide_t dx, dy;
	logic            hidden;
	stoe_pkg::word_t map_word;
	logic [3:0]      cols_sat, rows_sat;

	assign request.ready = (state_q == ST_IDLE);
	assign req_accept    = request.valid && request.ready;
	assign advance       = !out_valid_q || result.ready;
	assign issue         = (state_q == ST_EMIT) && advance;

	// Size saturation at the maximum tile counts
	assign cols_sat = (32'(request.cols) > 32'(MAX_COLS)) ? 4'(MAX_COLS) : request.cols;
	assign rows_sat = (32'(request.rows) > 32'(MAX_ROWS)) ? 4'(MAX_ROWS) : request.rows;

	// Fold start address and slot base into range, one subtract per cycle
	assign start_big = 32'(start_q) >= 32'(MAP_DEPTH);
	assign base_big  = 32'(base_q) >= 32'(OBJECT_SLOTS);
	assign prep_done = !start_big && !base_big;

	assign flip_x   = (attr_q & stoe_pkg::FLIP_X_MASK) != '0;
	assign flip_y   = (attr_q & stoe_pkg::FLIP_Y_MASK) != '0;
	assign row_end  = (col_q == cols_q - 4'd1);
	assign tile_end = row_end && (row_q == rows_q - 4'd1);

	// Window test: offsets compared as unsigned after margin
	assign dy = {{2{y_q[15]}}, y_q} - {{2{view_top_q[15]}}, view_top_q} + stoe_pkg::ROW_MARGIN;
	assign dx = {{2{x_q[15]}}, x_q} - {{2{view_left_q[15]}}, view_left_q}
		+ stoe_pkg::COL_MARGIN;
	assign hidden = (dy > ylim_q) || (dx > xlim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_accept) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (prep_done) begin
						if (action_q == stoe_pkg::ACT_LOAD || cols_q == '0 || rows_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (issue && tile_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Transaction fields, origin set-up and tile walk
	always_ff @(posedge clk) begin
		if (req_accept) begin
			action_q   <= request.action;
			start_q    <= (request.action == stoe_pkg::ACT_LOAD) ? request.map_address
				: request.map_start;
			base_q     <= request.base_index;
			map_data_q <= request.map_data;
			pos_x_q    <= request.pos_x;
			pos_y_q    <= request.pos_y;
			attr_q     <= request.attribute_word;
			tbase_q    <= (request.attribute_word & stoe_pkg::FLIP_MASK)
				| {request.palette, 14'(0)} | {5'b0, request.char_offset};
			cols_q     <= cols_sat;
			rows_q     <= rows_sat;
		end
		if (state_q == ST_PREP) begin
			if (start_big) begin
				start_q <= start_q - 10'(MAP_DEPTH);
			end
			if (base_big) begin
				base_q <= base_q - 10'(OBJECT_SLOTS);
			end
			addr_q <= AW'(start_q);
			obj_q  <= OW'(base_q);
			col_q  <= '0;
			row_q  <= '0;
			xlim_q <= {{2{view_right_q[15]}}, view_right_q}
				- {{2{view_left_q[15]}}, view_left_q} + stoe_pkg::COL_MARGIN;
			ylim_q <= {{2{view_bottom_q[15]}}, view_bottom_q}
				- {{2{view_top_q[15]}}, view_top_q} + stoe_pkg::ROW_MARGIN;
			if (flip_x) begin
				x0_q <= pos_x_q + {10'b0, cols_q, 2'b00} - {{8{flip_x_ofs_q[7]}}, flip_x_ofs_q};
				x_q  <= pos_x_q + {10'b0, cols_q, 2'b00} - {{8{flip_x_ofs_q[7]}}, flip_x_ofs_q};
			end else begin
				x0_q <= pos_x_q - {10'b0, cols_q, 2'b00};
				x_q  <= pos_x_q - {10'b0, cols_q, 2'b00};
			end
			if (flip_y) begin
				y_q <= pos_y_q + {10'b0, rows_q, 2'b00} - {{8{flip_y_ofs_q[7]}}, flip_y_ofs_q};
			end else begin
				y_q <= pos_y_q - {10'b0, rows_q, 2'b00};
			end
		end
		if (issue) begin
			addr_q <= (addr_q == AW'(MAP_DEPTH - 1)) ? '0 : addr_q + AW'(1);
			obj_q  <= (obj_q == OW'(OBJECT_SLOTS - 1)) ? '0 : obj_q + OW'(1);
			if (row_end) begin
				col_q <= '0;
				row_q <= row_q + 4'd1;
				x_q   <= x0_q;
				y_q   <= flip_y ? y_q - stoe_pkg::TILE_STEP : y_q + stoe_pkg::TILE_STEP;
			end else begin
				col_q <= col_q + 4'd1;
				x_q   <= flip_x ? x_q - stoe_pkg::TILE_STEP : x_q + stoe_pkg::TILE_STEP;
			end
		end
	end

	// Map store
	stoe_ram #(
		.WIDTH (16),
		.DEPTH (MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (state_q == ST_PREP && prep_done && action_q == stoe_pkg::ACT_LOAD),
		.waddr (AW'(start_q)),
		.wdata (map_data_q),
		.re    (issue),
		.raddr (addr_q),
		.rdata (map_word)
	);

	// Pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= issue;
			out_valid_q <= valid_s1;
		end
	end

	// Tile payload in flight with its map read, then output register
	always_ff @(posedge clk) begin
		if (advance) begin
			if (issue) begin
				obj_s1   <= obj_q;
				vis_s1   <= !hidden;
				head_s1  <= hidden ? hide_word_q : attr_q;
				x_s1     <= hidden ? '0 : x_q;
				y_s1     <= hidden ? '0 : y_q;
				tbase_s1 <= tbase_q;
				last_s1  <= tile_end;
			end
			if (valid_s1) begin
				out_obj_q  <= 10'(obj_s1);
				out_vis_q  <= vis_s1;
				out_head_q <= head_s1;
				out_x_q    <= x_s1;
				out_y_q    <= y_s1;
				out_tile_q <= vis_s1 ? tbase_s1 + map_word : '0;
				out_last_q <= last_s1;
			end
		end
	end

	assign result.valid     = out_valid_q;
	assign result.obj_index = out_obj_q;
	assign result.visible   = out_vis_q;
	assign result.head_word = out_head_q;
	assign result.x_pos     = out_x_q;
	assign result.y_pos     = out_y_q;
	assign result.tile_word = out_tile_q;
	assign result.last      = out_last_q;

endmodule

`default_nettype wire
